>>> sv/dctd_pkg.sv
// Shared constants, command and status types, and count arithmetic for the divisor counter.
package dctd_pkg;

  localparam int SIEVE_LIMIT = 32768;
  localparam int PRIME_COUNT = 3512;
  localparam int SIEVE_ROOT  = 181;

  localparam int VALW = 30;
  localparam int CNTW = 11;
  localparam int EW   = 5;

  localparam int IN_TW  = ((VALW + 7) / 8) * 8;
  localparam int OUT_TW = ((CNTW + 7) / 8) * 8;

  localparam int VW         = $clog2(SIEVE_LIMIT);
  localparam int MARK_DEPTH = SIEVE_LIMIT / 2;
  localparam int MW         = $clog2(MARK_DEPTH);
  localparam int OW         = $clog2(SIEVE_ROOT + 3);
  localparam int CW         = $clog2(SIEVE_LIMIT + 2);
  localparam int JSPAN      = (SIEVE_LIMIT + 2 * SIEVE_ROOT > SIEVE_ROOT * SIEVE_ROOT + 1) ?
                              SIEVE_LIMIT + 2 * SIEVE_ROOT : SIEVE_ROOT * SIEVE_ROOT + 1;
  localparam int JW         = $clog2(JSPAN + 1);
  localparam int PW         = $clog2(PRIME_COUNT + 1);
  localparam int TAW        = $clog2(PRIME_COUNT);
  localparam int DCW        = $clog2(VALW);
  localparam int CMPW       = (2 * VW > VALW) ? 2 * VW : VALW;

  localparam logic [CNTW-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic clr_step;
    logic outer_init;
    logic rd_coll;
    logic outer_step;
    logic strike_init;
    logic strike_step;
    logic coll_init;
    logic coll_step;
    logic item_load;
    logic div_start;
    logic div_take;
    logic prime_next;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mark;
    logic oi_last;
    logic strike_end;
    logic coll_last;
    logic coll_full;
    logic prime_stop;
    logic div_done;
    logic div_zero;
    logic out_free;
  } sts_t;

  function automatic logic [CNTW-1:0] sat_mul(input logic [CNTW-1:0] a,
                                              input logic [EW-1:0] b);
    logic [CNTW+EW-1:0] p;
    p = (CNTW + EW)'(a) * (CNTW + EW)'(b);
    return (p > (CNTW + EW)'(COUNT_MAX)) ? COUNT_MAX : p[CNTW-1:0];
  endfunction

endpackage

>>> sv/divisor_count_trial_division.sv
// Top level of the divisor counter: stream ports, controller and datapath.
// After reset the block clears its 16384-entry composite-mark memory, strikes odd multiples
// of the small primes, then walks all odd candidates to fill a table of up to 3512 primes;
// during all of this s_axis_tready stays low. Each request is then factorized by trial
// division over that table. Every prime tried costs a table lookup and a square test, plus
// one trial division in the one-bit-per-cycle divider (one more division and one restart
// state per factor found). Requests are handled one at a time; the next request is taken
// while a finished count still waits in the output register.
module divisor_count_trial_division (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [dctd_pkg::IN_TW-1:0]    s_axis_tdata,   // [29:0] value
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [dctd_pkg::OUT_TW-1:0]   m_axis_tdata    // [10:0] divisor_count
);

  dctd_pkg::cmd_t                 cmd;
  dctd_pkg::sts_t                 sts;
  logic [dctd_pkg::CNTW-1:0]      out_count;

  dctd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dctd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_value  (s_axis_tdata[dctd_pkg::VALW-1:0]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_count (out_count)
  );

  assign m_axis_tdata = dctd_pkg::OUT_TW'(out_count);

endmodule

>>> sv/dctd_div.sv
// Restoring divider, one quotient bit per cycle.
module dctd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dctd_pkg::VALW-1:0]     dividend,
  input  logic [dctd_pkg::VW-1:0]       divisor,
  output logic                          done,
  output logic [dctd_pkg::VALW-1:0]     quot,
  output logic                          rmd_zero
);

  logic                        busy;
  logic [dctd_pkg::DCW-1:0]    cnt;
  logic [dctd_pkg::VALW-1:0]   q;
  logic [dctd_pkg::VW-1:0]     r;
  logic [dctd_pkg::VW-1:0]     d;
  logic [dctd_pkg::VW:0]       trial;

  assign trial    = {r, q[dctd_pkg::VALW-1]};
  assign quot     = q;
  assign rmd_zero = (r == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == dctd_pkg::DCW'(dctd_pkg::VALW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      r   <= '0;
      d   <= divisor;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (trial >= {1'b0, d}) begin
        r <= dctd_pkg::VW'(trial - {1'b0, d});
        q <= {q[dctd_pkg::VALW-2:0], 1'b1};
      end else begin
        r <= trial[dctd_pkg::VW-1:0];
        q <= {q[dctd_pkg::VALW-2:0], 1'b0};
      end
    end
  end

endmodule

>>> sv/dctd_dp.sv
// Datapath: sieve memories and counters, trial division registers, result register.
module dctd_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  dctd_pkg::cmd_t                cmd,
  output dctd_pkg::sts_t                sts,
  input  logic [dctd_pkg::VALW-1:0]     in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dctd_pkg::CNTW-1:0]     out_count
);

  logic                               marks [dctd_pkg::MARK_DEPTH];
  logic [dctd_pkg::VW-1:0]            ptab  [dctd_pkg::PRIME_COUNT];

  logic [dctd_pkg::MW-1:0]            clr_addr;
  logic [dctd_pkg::OW-1:0]            oi;
  logic [dctd_pkg::JW-1:0]            j;
  logic [dctd_pkg::CW-1:0]            cc;
  logic [dctd_pkg::PW-1:0]            found;
  logic [dctd_pkg::PW-1:0]            idx;
  logic                               mark_q;
  logic [dctd_pkg::VW-1:0]            p_q;
  logic [dctd_pkg::VALW-1:0]          rem;
  logic [dctd_pkg::EW-1:0]            e;
  logic [dctd_pkg::CNTW-1:0]          count;

  logic                               mark_we;
  logic [dctd_pkg::MW-1:0]            mark_waddr;
  logic                               mark_wdata;
  logic [dctd_pkg::MW-1:0]            mark_raddr;
  logic                               tab_we;
  logic [dctd_pkg::TAW-1:0]           tab_waddr;
  logic [dctd_pkg::VW-1:0]            tab_wdata;
  logic [2*dctd_pkg::VW-1:0]          psq;
  logic                               div_done;
  logic [dctd_pkg::VALW-1:0]          div_quot;
  logic                               div_zero;

  always_comb begin
    mark_we    = cmd.clr_step | cmd.strike_step;
    mark_waddr = cmd.clr_step ? clr_addr : dctd_pkg::MW'(j >> 1);
    mark_wdata = ~cmd.clr_step;
    mark_raddr = cmd.rd_coll ? dctd_pkg::MW'(cc >> 1) : dctd_pkg::MW'(oi >> 1);
    tab_we     = cmd.coll_init | (cmd.coll_step & ~mark_q);
    tab_waddr  = cmd.coll_init ? '0 : found[dctd_pkg::TAW-1:0];
    tab_wdata  = cmd.coll_init ? dctd_pkg::VW'(2) : cc[dctd_pkg::VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      marks[mark_waddr] <= mark_wdata;
    end
    mark_q <= marks[mark_raddr];
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      ptab[tab_waddr] <= tab_wdata;
    end
    p_q <= ptab[idx[dctd_pkg::TAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      found    <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.coll_init) begin
        found <= dctd_pkg::PW'(1);
      end else if (cmd.coll_step && !mark_q) begin
        found <= found + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.outer_init) begin
      oi <= dctd_pkg::OW'(3);
    end else if (cmd.outer_step) begin
      oi <= oi + dctd_pkg::OW'(2);
    end
    if (cmd.strike_init) begin
      j <= dctd_pkg::JW'(oi) * dctd_pkg::JW'(oi);
    end else if (cmd.strike_step) begin
      j <= j + (dctd_pkg::JW'(oi) << 1);
    end
    if (cmd.coll_init) begin
      cc <= dctd_pkg::CW'(3);
    end else if (cmd.coll_step) begin
      cc <= cc + dctd_pkg::CW'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      rem   <= in_value;
      e     <= '0;
      count <= dctd_pkg::CNTW'(1);
      idx   <= '0;
    end else begin
      if (cmd.div_take) begin
        rem <= div_quot;
        e   <= e + 1'b1;
      end
      if (cmd.prime_next) begin
        if (e != '0) begin
          count <= dctd_pkg::sat_mul(count, e + 1'b1);
        end
        e   <= '0;
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_count <= dctd_pkg::sat_mul(count, (rem > dctd_pkg::VALW'(1)) ?
                                     dctd_pkg::EW'(2) : dctd_pkg::EW'(1));
    end
  end

  assign psq = (2 * dctd_pkg::VW)'(p_q) * (2 * dctd_pkg::VW)'(p_q);

  dctd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (rem),
    .divisor  (p_q),
    .done     (div_done),
    .quot     (div_quot),
    .rmd_zero (div_zero)
  );

  always_comb begin
    sts.clr_last   = (clr_addr == dctd_pkg::MW'(dctd_pkg::MARK_DEPTH - 1));
    sts.mark       = mark_q;
    sts.oi_last    = ((dctd_pkg::OW + 1)'(oi) + (dctd_pkg::OW + 1)'(2)) >
                     (dctd_pkg::OW + 1)'(dctd_pkg::SIEVE_ROOT);
    sts.strike_end = (j >= dctd_pkg::JW'(dctd_pkg::SIEVE_LIMIT));
    sts.coll_last  = ((dctd_pkg::CW + 1)'(cc) + (dctd_pkg::CW + 1)'(2)) >=
                     (dctd_pkg::CW + 1)'(dctd_pkg::SIEVE_LIMIT);
    sts.coll_full  = (found >= dctd_pkg::PW'(dctd_pkg::PRIME_COUNT));
    sts.prime_stop = (idx >= found) ||
                     (dctd_pkg::CMPW'(psq) > dctd_pkg::CMPW'(rem));
    sts.div_done   = div_done;
    sts.div_zero   = div_zero;
    sts.out_free   = ~out_valid | out_ready;
  end

endmodule

>>> sv/dctd_ctrl.sv
// Controller: sieve sequencing after reset and trial division per request.
module dctd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dctd_pkg::sts_t    sts,
  output dctd_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_O_RD   = 4'd1;
  localparam logic [3:0] S_O_CHK  = 4'd2;
  localparam logic [3:0] S_STRIKE = 4'd3;
  localparam logic [3:0] S_C_RD   = 4'd4;
  localparam logic [3:0] S_C_CHK  = 4'd5;
  localparam logic [3:0] S_IDLE   = 4'd6;
  localparam logic [3:0] S_P_RD   = 4'd7;
  localparam logic [3:0] S_P_CHK  = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_DIV_GO = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          cmd.outer_init = 1'b1;
          state_next     = S_O_RD;
        end
      end
      S_O_RD: begin
        state_next = S_O_CHK;
      end
      S_O_CHK: begin
        if (sts.mark) begin
          cmd.outer_step = 1'b1;
          if (sts.oi_last) begin
            cmd.coll_init = 1'b1;
            state_next    = S_C_RD;
          end else begin
            state_next = S_O_RD;
          end
        end else begin
          cmd.strike_init = 1'b1;
          state_next      = S_STRIKE;
        end
      end
      S_STRIKE: begin
        if (!sts.strike_end) begin
          cmd.strike_step = 1'b1;
        end else begin
          cmd.outer_step = 1'b1;
          if (sts.oi_last) begin
            cmd.coll_init = 1'b1;
            state_next    = S_C_RD;
          end else begin
            state_next = S_O_RD;
          end
        end
      end
      S_C_RD: begin
        cmd.rd_coll = 1'b1;
        state_next  = S_C_CHK;
      end
      S_C_CHK: begin
        if (!sts.mark && sts.coll_full) begin
          state_next = S_IDLE;
        end else begin
          cmd.coll_step = 1'b1;
          state_next    = sts.coll_last ? S_IDLE : S_C_RD;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.item_load = 1'b1;
          state_next    = S_P_RD;
        end
      end
      S_P_RD: begin
        state_next = S_P_CHK;
      end
      S_P_CHK: begin
        if (sts.prime_stop) begin
          state_next = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (sts.div_zero) begin
            cmd.div_take = 1'b1;
            state_next   = S_DIV_GO;
          end else begin
            cmd.prime_next = 1'b1;
            state_next     = S_P_RD;
          end
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLR;
      end
    endcase
  end

endmodule

>>> sv/dctd_chk.sv
// Port checker for the divisor counter and its bind to the top level.
module dctd_chk (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [dctd_pkg::OUT_TW-1:0]   m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[dctd_pkg::CNTW-1:0] != '0 &&
                      (m_axis_tdata >> dctd_pkg::CNTW) == '0)
    else $error("divisor count out of range");

  a_sieve_busy: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("request taken before sieve finished");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while one is in work");

endmodule

bind divisor_count_trial_division dctd_chk u_dctd_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> test/tb.sv
// Self-checking testbench for the divisor counter: streams values in, checks each count.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIEVE_LIMIT = dctd_pkg::SIEVE_LIMIT;
  localparam int SIEVE_ROOT  = dctd_pkg::SIEVE_ROOT;
  localparam int PRIME_COUNT = dctd_pkg::PRIME_COUNT;
  localparam int VALW        = dctd_pkg::VALW;
  localparam int CNTW        = dctd_pkg::CNTW;
  localparam int IN_TW       = dctd_pkg::IN_TW;
  localparam int OUT_TW      = dctd_pkg::OUT_TW;

  // Bound on simulated cycles: 100 requests of the longest kind plus the sieve pass, with margin.
  localparam longint CYCLE_LIMIT = 50_000_000;
  localparam int unsigned COUNT_CAP = (1 << CNTW) - 1;
  localparam int RANDOM_REQUESTS = 80;

  class count_scoreboard;
    bit composite [SIEVE_LIMIT/2 + 1];
    int unsigned primes[$];
    logic [CNTW-1:0] expected_counts[$];
    int errors;

    function new();
      int unsigned i;
      int unsigned j;
      errors = 0;
      for (i = 3; i <= SIEVE_ROOT; i += 2) begin
        if (!composite[i >> 1]) begin
          for (j = i * i; j < SIEVE_LIMIT; j += 2 * i) composite[j >> 1] = 1'b1;
        end
      end
      if (SIEVE_LIMIT > 2) primes = {primes, 32'd2};
      for (i = 3; i < SIEVE_LIMIT && primes.size() < PRIME_COUNT; i += 2) begin
        if (!composite[i >> 1]) primes = {primes, i};
      end
    endfunction

    function logic [CNTW-1:0] divisors_of(logic [VALW-1:0] v);
      longint unsigned rem;
      longint unsigned p;
      int unsigned cnt;
      int unsigned e;
      int k;
      rem = v;
      cnt = 1;
      for (k = 0; k < primes.size(); k++) begin
        p = primes[k];
        if (p * p > rem) break;
        e = 0;
        while (rem % p == 0) begin
          rem = rem / p;
          e++;
        end
        if (e != 0) begin
          cnt = cnt * (e + 1);
          if (cnt > COUNT_CAP) cnt = COUNT_CAP;
        end
      end
      if (rem > 1) begin
        cnt = cnt * 2;
        if (cnt > COUNT_CAP) cnt = COUNT_CAP;
      end
      return CNTW'(cnt);
    endfunction

    function void note_value(logic [VALW-1:0] v);
      expected_counts = {expected_counts, divisors_of(v)};
    endfunction

    function void check_count(logic [CNTW-1:0] got);
      logic [CNTW-1:0] want;
      if (expected_counts.size() == 0) begin
        $error("divisor_count: expected none, actual %0d", got);
        errors++;
      end else begin
        want = expected_counts.pop_front();
        if (got !== want) begin
          $error("divisor_count: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_TW-1:0]  s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_TW-1:0] m_axis_tdata;
  logic              steady;
  longint            cycles;
  count_scoreboard   sb;

  divisor_count_trial_division u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever @(negedge clk) m_axis_tready = steady || ($urandom_range(0, 99) >= 9);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_count(m_axis_tdata[CNTW-1:0]);
  end

  // Enter and leave at a falling edge; hold the request until the block takes it.
  task automatic send_request(input logic [IN_TW-1:0] word);
    while (!steady && $urandom_range(0, 99) < 9) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = word;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_value(word[VALW-1:0]);
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (sb.expected_counts.size() != 0) @(negedge clk);
  endtask

  function automatic logic [VALW-1:0] smooth_value();
    longint unsigned acc;
    longint unsigned p;
    int k;
    acc = 1;
    k = $urandom_range(1, 14);
    repeat (k) begin
      p = sb.primes[$urandom_range(0, 9)];
      if (acc * p < (64'd1 << VALW)) acc = acc * p;
    end
    if ($urandom_range(0, 2) == 0) begin
      p = sb.primes[$urandom_range(10, sb.primes.size() - 1)];
      if (acc * p < (64'd1 << VALW)) acc = acc * p;
    end
    return VALW'(acc);
  endfunction

  initial begin
    logic [IN_TW-1:0] directed_words [20];
    logic [VALW-1:0]  v;
    int               n;
    int               pick;

    directed_words = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4,
      32'h3FFF_FFFF, 32'd536870912, 32'd387420489, 32'd735134400, 32'd223092870,
      32'd32761, 32'd32749, 32'd32768, 32'd1072497001, 32'd1071514531,
      32'd1073741789, 32'hEAAA_AAAA, 32'h5555_5555, 32'hC000_0001, 32'h4000_0000
    };

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    steady        = 1'b0;
    sb            = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_words[i]) send_request(directed_words[i]);
    s_axis_tvalid = 1'b0;
    drain_results();

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      steady = (n >= 40 && n < 70);
      pick = $urandom_range(0, 99);
      if (pick < 45) v = smooth_value();
      else if (pick < 80) v = VALW'($urandom_range(0, 65535));
      else if (pick < 97) v = VALW'($urandom_range(0, (1 << 20) - 1));
      else v = VALW'($urandom);
      send_request({IN_TW'($urandom_range(0, 3)) << VALW} | IN_TW'(v));
      if (n == 75) begin
        s_axis_tvalid = 1'b0;
        drain_results();
      end
    end
    s_axis_tvalid = 1'b0;
    steady        = 1'b0;

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_counts.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
sv/dctd_pkg.sv
sv/dctd_div.sv
sv/dctd_dp.sv
sv/dctd_ctrl.sv
sv/divisor_count_trial_division.sv
sv/dctd_chk.sv
test/tb.sv
